/* rtl/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Types, constants and the sigmoid table shared by the trainer modules.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int FEATURES            = 4;
  localparam int NFEAT_MAX           = 4;
  localparam int SIGMOID_TABLE_DEPTH = 256;
  localparam int IDX_W               = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int LANES               = FEATURES + 1;  // last lane carries the bias
  localparam int PROD_W              = 48;
  localparam int SUM_W               = 48;
  localparam int ERR_W               = 17;
  localparam int ACT_W               = 52;
  localparam int CNT_W               = 24;

  localparam logic [15:0]        STEP_GAIN_RST   = 16'd655;
  localparam logic signed [31:0] INIT_WEIGHT_RST = 32'sd16777216;
  localparam logic signed [31:0] INIT_BIAS_RST   = 32'sd0;

  localparam logic [1:0] REQ_TRAIN    = 2'd0;
  localparam logic [1:0] REQ_CLASSIFY = 2'd1;
  localparam logic [1:0] REQ_RESTART  = 2'd2;

  localparam logic [1:0] CFG_STEP_GAIN      = 2'd0;
  localparam logic [1:0] CFG_INITIAL_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_INITIAL_BIAS   = 2'd2;

  localparam int CNT_TP = 0;
  localparam int CNT_TN = 1;
  localparam int CNT_FP = 2;
  localparam int CNT_FN = 3;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [15:0]  feature_0;
    logic signed [15:0]  feature_1;
    logic signed [15:0]  feature_2;
    logic signed [15:0]  feature_3;
    logic                label;
    logic                batch_end;
  } in_t;

  typedef struct packed {
    logic [15:0]         probability;
    logic                predicted;
    logic [CNT_W-1:0]    count_true_pos;
    logic [CNT_W-1:0]    count_true_neg;
    logic [CNT_W-1:0]    count_false_pos;
    logic [CNT_W-1:0]    count_false_neg;
    logic                updated;
    logic signed [31:0]  bias_now;
    logic signed [31:0]  weight_0_now;
    logic signed [31:0]  weight_1_now;
    logic signed [31:0]  weight_2_now;
    logic signed [31:0]  weight_3_now;
  } out_t;

  // per-lane step enables from the sequencer
  typedef struct packed {
    logic load;
    logic mul;
    logic gmul;
    logic acc;
    logic umul;
    logic upd;
  } lane_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACT, S_LOOK, S_GMUL, S_ACC, S_UMUL, S_UPD, S_DONE
  } state_t;

  typedef logic [15:0] sig_tab_t [SIGMOID_TABLE_DEPTH];

  // shift-subtract quotient, only evaluated while the table is built
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-|x|) = (exp(-|x|/16))^16 in Q.30 via a series through the 12th power
  function automatic sig_tab_t build_sig_table();
    sig_tab_t          t;
    longint            x;
    longint            sum;
    longint unsigned   ax, y, term, e, den, p;
    longint            one;
    one = 64'sd1 <<< 30;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      x    = (longint'(i) * 16 * one) / SIGMOID_TABLE_DEPTH - 8 * one;
      ax   = (x < 0) ? longint'(-x) : x;
      y    = ax >> 4;
      term = one;
      sum  = one;
      for (int n = 1; n <= 12; n++) begin
        term = udiv((term * y) >> 30, longint'(n));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      e = (sum < 0) ? 64'd0 : sum;
      for (int s = 0; s < 4; s++) e = (e * e) >> 30;
      den = one + e;
      if (x >= 0) p = udiv((64'd1 << 46) + (den >> 1), den);
      else        p = udiv((e << 16) + (den >> 1), den);
      t[i] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

/* rtl/lr_lane.sv */
// ----------------------------------------------------------------------------
// lr_lane
// One weight lane: product for the activation, gradient sum, saturating update.
// ----------------------------------------------------------------------------
module lr_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lr_pkg::lane_cmd_t                 cmd,
  input  logic signed [15:0]                act_feat,
  input  logic signed [15:0]                grad_feat,
  input  logic                              bias_mode,
  input  logic signed [lr_pkg::ERR_W-1:0]   err,
  input  logic [15:0]                       step_gain,
  input  logic signed [31:0]                init_value,
  input  logic signed [31:0]                rst_value,
  output logic signed [lr_pkg::PROD_W-1:0]  prod,
  output logic signed [31:0]                weight
);

  logic signed [31:0]                weight_r, weight_nxt;
  logic signed [lr_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [lr_pkg::PROD_W-1:0]  prod_r;
  logic signed [32:0]                gprod_r;
  logic signed [41:0]                pl_r, ph_r;
  logic signed [48:0]                acc_wide;
  logic signed [65:0]                full, delta, nw;

  always_comb begin
    acc_wide = 49'(sum_r) + 49'(gprod_r);
    if (acc_wide > 49'sh0_7FFF_FFFF_FFFF)        sum_nxt = 48'sh7FFF_FFFF_FFFF;
    else if (acc_wide < -49'sh0_8000_0000_0000)  sum_nxt = 48'sh8000_0000_0000;
    else                                         sum_nxt = acc_wide[47:0];

    // step_gain * sum rebuilt from two partial products, rounded half up
    full  = (66'(ph_r) <<< 24) + 66'(pl_r);
    delta = bias_mode ? ((full + 66'sd128) >>> 8) : ((full + 66'sd524288) >>> 20);
    nw    = 66'(weight_r) - delta;
    if (nw > 66'sd2147483647)        weight_nxt = 32'sh7FFF_FFFF;
    else if (nw < -66'sd2147483648)  weight_nxt = 32'sh8000_0000;
    else                             weight_nxt = nw[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= rst_value;
      sum_r    <= '0;
    end else if (cmd.load) begin
      weight_r <= init_value;
      sum_r    <= '0;
    end else begin
      if (cmd.acc) sum_r <= sum_nxt;
      if (cmd.upd) begin
        weight_r <= weight_nxt;
        sum_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul)  prod_r  <= weight_r * act_feat;
    if (cmd.gmul) gprod_r <= 33'(err) * 33'(grad_feat);
    if (cmd.umul) begin
      pl_r <= $signed({26'd0, step_gain}) * $signed({18'd0, sum_r[23:0]});
      // upper half of the sum carries the sign
      ph_r <= 42'($signed({1'b0, step_gain})) * 42'($signed(sum_r[47:24]));
    end
  end

  assign prod   = prod_r;
  assign weight = weight_r;

endmodule

/* rtl/lr_merge.sv */
// ----------------------------------------------------------------------------
// lr_merge
// Sums lane products into the activation, then looks up the sigmoid.
// ----------------------------------------------------------------------------
module lr_merge (
  input  logic                              clk,
  input  logic                              sum_en,
  input  logic                              look_en,
  input  logic signed [lr_pkg::PROD_W-1:0]  prods [lr_pkg::LANES],
  output logic [15:0]                       prob,
  output logic                              pred
);

  localparam logic signed [lr_pkg::ACT_W-1:0] OFFSET = 52'sd8 <<< 36;
  localparam logic signed [lr_pkg::ACT_W-1:0] SPAN   = 52'sd16 <<< 36;

  logic signed [lr_pkg::ACT_W-1:0] act_r, act_sum, off;
  logic [52:0]                     scaled;
  logic [lr_pkg::IDX_W-1:0]        idx;
  logic [15:0]                     prob_r;
  logic                            pred_r;

  always_comb begin
    act_sum = '0;
    for (int i = 0; i < lr_pkg::LANES; i++) act_sum = act_sum + lr_pkg::ACT_W'(prods[i]);
    off    = act_r + OFFSET;
    scaled = (53'(off[39:0]) * 53'(lr_pkg::SIGMOID_TABLE_DEPTH)) >> 40;
    if (off < 0)                 idx = '0;
    else if (off >= SPAN)        idx = lr_pkg::IDX_W'(lr_pkg::SIGMOID_TABLE_DEPTH - 1);
    else if (scaled >= 53'(lr_pkg::SIGMOID_TABLE_DEPTH))
                                 idx = lr_pkg::IDX_W'(lr_pkg::SIGMOID_TABLE_DEPTH - 1);
    else                         idx = scaled[lr_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (sum_en) act_r <= act_sum;
    if (look_en) begin
      prob_r <= lr_pkg::SIG_TABLE[idx];
      pred_r <= ~act_r[lr_pkg::ACT_W-1];
    end
  end

  assign prob = prob_r;
  assign pred = pred_r;

endmodule

/* rtl/logistic_regression_trainer.sv */
// ----------------------------------------------------------------------------
// logistic_regression_trainer
// Mini-batch logistic regression trainer and classifier, four features.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready/in_data; one result word per input
// leaves on out_valid/out_ready/out_data. cfg_we/cfg_index/cfg_wdata write
// step gain, initial weight and initial bias; write only while idle.
// One item at a time. After acceptance a train or classify item passes the
// lane multipliers, the activation adder and the table read; classify then
// counts, train forms and accumulates the gradient products and, with batch
// end, runs the two-step gradient update. Restart and the unused code go
// straight to the result. The result word becomes valid as the block returns to idle.
// in_ready is high in the idle state; the finished word sits in the output
// register, so the next item is taken while the receiver stalls, and the
// sequencer holds its result until the register frees up.
// Reset loads the weights and bias from the reset register values and
// clears the gradient sums and confusion counts.
// ----------------------------------------------------------------------------
module logistic_regression_trainer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lr_pkg::in_t    in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lr_pkg::out_t   out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  lr_pkg::state_t      state_r, state_nxt;
  lr_pkg::in_t         item_r;
  lr_pkg::lane_cmd_t   cmd;
  lr_pkg::out_t        out_r;
  logic                out_valid_r;
  logic [15:0]         step_gain_r;
  logic signed [31:0]  init_w_r, init_b_r;
  logic [lr_pkg::CNT_W-1:0] cnt_r [4];
  logic                valid_req_r, upd_r;
  logic                sum_en, look_en, emit, count_en, clr_cnt;
  logic [15:0]         prob;
  logic                pred;
  logic signed [17:0]  err_wide;
  logic signed [lr_pkg::ERR_W-1:0] err;
  logic signed [15:0]  feat_a [lr_pkg::NFEAT_MAX];
  logic signed [lr_pkg::PROD_W-1:0] prods [lr_pkg::LANES];
  logic signed [31:0]  lw [lr_pkg::LANES];
  logic signed [31:0]  wout [lr_pkg::NFEAT_MAX];
  int unsigned         ci;

  assign feat_a[0] = item_r.feature_0;
  assign feat_a[1] = item_r.feature_1;
  assign feat_a[2] = item_r.feature_2;
  assign feat_a[3] = item_r.feature_3;

  assign err_wide = $signed({2'b00, prob}) - $signed({1'b0, item_r.label, 16'd0});
  assign err      = err_wide[lr_pkg::ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r <= lr_pkg::STEP_GAIN_RST;
      init_w_r    <= lr_pkg::INIT_WEIGHT_RST;
      init_b_r    <= lr_pkg::INIT_BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lr_pkg::CFG_STEP_GAIN:      step_gain_r <= cfg_wdata[15:0];
        lr_pkg::CFG_INITIAL_WEIGHT: init_w_r    <= cfg_wdata;
        lr_pkg::CFG_INITIAL_BIAS:   init_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < lr_pkg::FEATURES; g++) begin : g_lane
      lr_lane u_lane (
        .clk, .rst_n, .cmd,
        .act_feat(feat_a[g]), .grad_feat(feat_a[g]), .bias_mode(1'b0),
        .err, .step_gain(step_gain_r), .init_value(init_w_r),
        .rst_value(lr_pkg::INIT_WEIGHT_RST),
        .prod(prods[g]), .weight(lw[g])
      );
    end
    for (g = 0; g < lr_pkg::NFEAT_MAX; g++) begin : g_wout
      if (g < lr_pkg::FEATURES) begin : g_on
        assign wout[g] = lw[g];
      end else begin : g_off
        assign wout[g] = '0;
      end
    end
  endgenerate

  // bias lane: activation term bias*4096, gradient term err*1
  lr_lane u_bias (
    .clk, .rst_n, .cmd,
    .act_feat(16'sd4096), .grad_feat(16'sd1), .bias_mode(1'b1),
    .err, .step_gain(step_gain_r), .init_value(init_b_r),
    .rst_value(lr_pkg::INIT_BIAS_RST),
    .prod(prods[lr_pkg::FEATURES]), .weight(lw[lr_pkg::FEATURES])
  );

  lr_merge u_merge (
    .clk, .sum_en, .look_en, .prods, .prob, .pred
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lr_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    sum_en    = 1'b0;
    look_en   = 1'b0;
    emit      = 1'b0;
    count_en  = 1'b0;
    clr_cnt   = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      lr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.req_type == lr_pkg::REQ_TRAIN ||
              in_data.req_type == lr_pkg::REQ_CLASSIFY) state_nxt = lr_pkg::S_MUL;
          else begin
            state_nxt = lr_pkg::S_DONE;
            if (in_data.req_type == lr_pkg::REQ_RESTART) begin
              cmd.load = 1'b1;
              clr_cnt  = 1'b1;
            end
          end
        end
      end
      lr_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lr_pkg::S_ACT;
      end
      lr_pkg::S_ACT: begin
        sum_en    = 1'b1;
        state_nxt = lr_pkg::S_LOOK;
      end
      lr_pkg::S_LOOK: begin
        look_en   = 1'b1;
        state_nxt = lr_pkg::S_GMUL;
      end
      lr_pkg::S_GMUL: begin
        if (item_r.req_type == lr_pkg::REQ_CLASSIFY) begin
          count_en  = 1'b1;
          state_nxt = lr_pkg::S_DONE;
        end else begin
          cmd.gmul  = 1'b1;
          state_nxt = lr_pkg::S_ACC;
        end
      end
      lr_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = item_r.batch_end ? lr_pkg::S_UMUL : lr_pkg::S_DONE;
      end
      lr_pkg::S_UMUL: begin
        cmd.umul  = 1'b1;
        state_nxt = lr_pkg::S_UPD;
      end
      lr_pkg::S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = lr_pkg::S_DONE;
      end
      lr_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = lr_pkg::S_IDLE;
        end
      end
      default: state_nxt = lr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (pred) ci = item_r.label ? lr_pkg::CNT_TP : lr_pkg::CNT_FP;
    else      ci = item_r.label ? lr_pkg::CNT_FN : lr_pkg::CNT_TN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
    end else if (clr_cnt) begin
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
    end else if (count_en && cnt_r[ci[1:0]] != '1) begin
      cnt_r[ci[1:0]] <= cnt_r[ci[1:0]] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r      <= in_data;
      valid_req_r <= (in_data.req_type == lr_pkg::REQ_TRAIN ||
                      in_data.req_type == lr_pkg::REQ_CLASSIFY);
      upd_r       <= (in_data.req_type == lr_pkg::REQ_TRAIN) && in_data.batch_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (emit)         out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.probability     <= valid_req_r ? prob : 16'd0;
      out_r.predicted       <= valid_req_r & pred;
      out_r.count_true_pos  <= cnt_r[lr_pkg::CNT_TP];
      out_r.count_true_neg  <= cnt_r[lr_pkg::CNT_TN];
      out_r.count_false_pos <= cnt_r[lr_pkg::CNT_FP];
      out_r.count_false_neg <= cnt_r[lr_pkg::CNT_FN];
      out_r.updated         <= upd_r;
      out_r.bias_now        <= lw[lr_pkg::FEATURES];
      out_r.weight_0_now    <= wout[0];
      out_r.weight_1_now    <= wout[1];
      out_r.weight_2_now    <= wout[2];
      out_r.weight_3_now    <= wout[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != lr_pkg::S_IDLE)
    else $error("accepted word did not start the sequencer");
  a_upd_after_umul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lr_pkg::S_UPD |-> $past(state_r) == lr_pkg::S_UMUL)
    else $error("weight update without partial products");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("finished word not presented");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks logistic_regression_trainer against an independent predictor.
// Streams train, classify and restart words under random sender bursts and
// receiver stalls, across several register settings including the extremes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] REQ_NONE = 2'd3;  // unused request code, ignored by the block

  class lr_scoreboard;
    bit [15:0]       sig_lut [lr_pkg::SIGMOID_TABLE_DEPTH];
    bit [15:0]       gain;
    bit signed [31:0] init_w, init_b;
    bit signed [31:0] w [lr_pkg::NFEAT_MAX];
    bit signed [31:0] b;
    longint          gsum [lr_pkg::NFEAT_MAX];
    longint          bsum;
    bit [lr_pkg::CNT_W-1:0] cnt [4];
    lr_pkg::out_t    expected_q [$];
    int              errors, n_train, n_class, n_restart, n_upd, n_seen;

    function new();
      longint one, x, sum;
      longint unsigned ax, y, term, e, den, p;
      one = 64'sd1 <<< 30;
      for (int i = 0; i < lr_pkg::SIGMOID_TABLE_DEPTH; i++) begin
        x = (longint'(i) * 16 * one) / lr_pkg::SIGMOID_TABLE_DEPTH - 8 * one;
        ax = (x < 0) ? -x : x;
        y = ax >> 4;
        term = one;
        sum = one;
        for (int n = 1; n <= 12; n++) begin
          term = ((term * y) >> 30) / n;
          sum = (n % 2) ? sum - longint'(term) : sum + longint'(term);
        end
        e = (sum < 0) ? 0 : sum;
        repeat (4) e = (e * e) >> 30;
        den = one + e;
        p = (x >= 0) ? ((64'd1 << 46) + den / 2) / den : ((e << 16) + den / 2) / den;
        sig_lut[i] = (p > 65535) ? 16'hFFFF : p[15:0];
      end
      gain = 655;
      init_w = 32'sd16777216;
      init_b = 0;
      reload();
    endfunction

    function void reload();
      foreach (w[i]) begin
        w[i] = init_w;
        gsum[i] = 0;
      end
      b = init_b;
      bsum = 0;
      foreach (cnt[i]) cnt[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        lr_pkg::CFG_STEP_GAIN:      gain = v[15:0];
        lr_pkg::CFG_INITIAL_WEIGHT: init_w = v;
        lr_pkg::CFG_INITIAL_BIAS:   init_b = v;
        default: ;
      endcase
    endfunction

    function longint clip48(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
    endfunction

    function bit signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_input(lr_pkg::in_t d);
      longint f [lr_pkg::NFEAT_MAX];
      longint act, off, err;
      int     idx, c;
      lr_pkg::out_t r;
      r = '0;
      f[0] = d.feature_0; f[1] = d.feature_1; f[2] = d.feature_2; f[3] = d.feature_3;
      if (d.req_type == lr_pkg::REQ_TRAIN || d.req_type == lr_pkg::REQ_CLASSIFY) begin
        act = longint'(b) * 4096;
        for (int i = 0; i < lr_pkg::FEATURES; i++) act += longint'(w[i]) * f[i];
        off = act + (64'sd8 <<< 36);
        if (off < 0) idx = 0;
        else if (off >= (64'sd16 <<< 36)) idx = lr_pkg::SIGMOID_TABLE_DEPTH - 1;
        else idx = (off * lr_pkg::SIGMOID_TABLE_DEPTH) >>> 40;
        if (idx >= lr_pkg::SIGMOID_TABLE_DEPTH) idx = lr_pkg::SIGMOID_TABLE_DEPTH - 1;
        r.probability = sig_lut[idx];
        r.predicted = (act >= 0);
        if (d.req_type == lr_pkg::REQ_CLASSIFY) begin
          n_class++;
          c = r.predicted ? (d.label ? lr_pkg::CNT_TP : lr_pkg::CNT_FP)
                          : (d.label ? lr_pkg::CNT_FN : lr_pkg::CNT_TN);
          if (cnt[c] != {lr_pkg::CNT_W{1'b1}}) cnt[c]++;
        end else begin
          n_train++;
          err = longint'(r.probability) - (d.label ? 65536 : 0);
          bsum = clip48(bsum + err);
          for (int i = 0; i < lr_pkg::FEATURES; i++) gsum[i] = clip48(gsum[i] + err * f[i]);
          if (d.batch_end) begin
            for (int i = 0; i < lr_pkg::FEATURES; i++) begin
              w[i] = clip32(longint'(w[i]) -
                            ((longint'(gain) * gsum[i] + (64'sd1 <<< 19)) >>> 20));
              gsum[i] = 0;
            end
            b = clip32(longint'(b) - ((longint'(gain) * bsum + 64'sd128) >>> 8));
            bsum = 0;
            r.updated = 1;
            n_upd++;
          end
        end
      end else if (d.req_type == lr_pkg::REQ_RESTART) begin
        n_restart++;
        reload();
      end
      r.count_true_pos = cnt[lr_pkg::CNT_TP];
      r.count_true_neg = cnt[lr_pkg::CNT_TN];
      r.count_false_pos = cnt[lr_pkg::CNT_FP];
      r.count_false_neg = cnt[lr_pkg::CNT_FN];
      r.bias_now = b;
      r.weight_0_now = (lr_pkg::FEATURES > 0) ? w[0] : 0;
      r.weight_1_now = (lr_pkg::FEATURES > 1) ? w[1] : 0;
      r.weight_2_now = (lr_pkg::FEATURES > 2) ? w[2] : 0;
      r.weight_3_now = (lr_pkg::FEATURES > 3) ? w[3] : 0;
      expected_q = {expected_q, r};
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check(lr_pkg::out_t a);
      lr_pkg::out_t e;
      n_seen++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("probability", e.probability, a.probability);
      cmp("predicted", e.predicted, a.predicted);
      cmp("count_true_pos", e.count_true_pos, a.count_true_pos);
      cmp("count_true_neg", e.count_true_neg, a.count_true_neg);
      cmp("count_false_pos", e.count_false_pos, a.count_false_pos);
      cmp("count_false_neg", e.count_false_neg, a.count_false_neg);
      cmp("updated", e.updated, a.updated);
      cmp("bias_now", e.bias_now, a.bias_now);
      cmp("weight_0_now", e.weight_0_now, a.weight_0_now);
      cmp("weight_1_now", e.weight_1_now, a.weight_1_now);
      cmp("weight_2_now", e.weight_2_now, a.weight_2_now);
      cmp("weight_3_now", e.weight_3_now, a.weight_3_now);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n;
  logic         in_valid, in_ready, out_valid, out_ready, cfg_we;
  lr_pkg::in_t  in_data;
  lr_pkg::out_t out_data;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  lr_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0, stall_left = 0;

  logistic_regression_trainer dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: mode switches now and then between always-ready, random, long stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(lr_pkg::in_t d);
    int gap;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic lr_pkg::in_t make_word(logic [1:0] req, logic lbl, logic bend, bit wide);
    lr_pkg::in_t d;
    d.req_type = req;
    d.label = lbl;
    d.batch_end = bend;
    d.feature_0 = wide ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    d.feature_1 = wide ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    d.feature_2 = wide ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    d.feature_3 = wide ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    return d;
  endfunction

  task automatic send_fixed(logic [1:0] req, logic [15:0] f, logic lbl, logic bend);
    lr_pkg::in_t d;
    d = '{req, f, f, f, f, lbl, bend};
    send_word(d);
  endtask

  logic [31:0] gains [8] = '{0, 65535, 655, 1, 40000, 3000, 200, 655};
  logic [31:0] wts   [8] = '{32'h7FFFFFFF, 32'h80000000, 0, 32'h01000000,
                             32'hFF000000, 32'h00400000, 32'h00100000, 32'h01000000};
  logic [31:0] biases[8] = '{32'h80000000, 32'h7FFFFFFF, 0, 32'h00800000,
                             32'hFF800000, 0, 32'h02000000, 0};

  initial begin
    int n, blen;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= lr_pkg::CFG_STEP_GAIN;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, extremes, each request code
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'h0000, 1, 0);
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'h7FFF, 0, 0);
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'h8000, 1, 0);
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'h8000, 0, 0);
    send_fixed(lr_pkg::REQ_TRAIN, 16'h7FFF, 0, 0);
    send_fixed(lr_pkg::REQ_TRAIN, 16'h8000, 1, 0);
    send_fixed(lr_pkg::REQ_TRAIN, 16'h1000, 1, 1);
    send_fixed(lr_pkg::REQ_TRAIN, 16'hF000, 0, 1);
    send_fixed(REQ_NONE, 16'hFFFF, 1, 1);
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'h0800, 1, 0);
    send_fixed(lr_pkg::REQ_RESTART, 16'h5555, 1, 1);
    send_fixed(lr_pkg::REQ_CLASSIFY, 16'hAAAA, 0, 0);
    send_fixed(lr_pkg::REQ_TRAIN, 16'h7FFF, 1, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(lr_pkg::CFG_STEP_GAIN, gains[ph]);
      write_reg(lr_pkg::CFG_INITIAL_WEIGHT, wts[ph]);
      write_reg(lr_pkg::CFG_INITIAL_BIAS, biases[ph]);
      send_fixed(lr_pkg::REQ_RESTART, 16'h0000, 0, 0);
      n = 0;
      while (n < 200) begin
        case ($urandom_range(0, 19))
          0: send_word(make_word(lr_pkg::REQ_RESTART, 1'($urandom), 1'($urandom), 1));
          1: send_word(make_word(REQ_NONE, 1'($urandom), 1'($urandom), 1));
          2, 3, 4, 5, 6: begin
            send_word(make_word(lr_pkg::REQ_CLASSIFY, 1'($urandom), 1'($urandom),
                                $urandom_range(0, 3) == 0));
            n++;
          end
          default: begin
            blen = $urandom_range(1, 8);
            for (int k = 0; k < blen; k++) begin
              send_word(make_word(lr_pkg::REQ_TRAIN, 1'($urandom),
                                  k == blen - 1 ? 1'b1 : $urandom_range(0, 9) == 0,
                                  $urandom_range(0, 3) == 0));
              n++;
            end
          end
        endcase
      end
      drain();
    end

    $display("ran %0d train, %0d classify, %0d restart words, %0d weight updates;",
             sb.n_train, sb.n_class, sb.n_restart, sb.n_upd);
    $display("%0d result words checked over 9 register settings", sb.n_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/lr_pkg.sv
rtl/lr_lane.sv
rtl/lr_merge.sv
rtl/logistic_regression_trainer.sv
tb/testbench.sv
